// File: sv/bdf_pkg.sv
// Package for the bounded denominator fraction block: sequencer state type.
`timescale 1ns / 1ps
package bdf_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_MP,
    S_MQ,
    S_CHK,
    S_X1,
    S_X2,
    S_X3,
    S_ADIV,
    S_AM1,
    S_AM2,
    S_AM3,
    S_OUT
  } bdf_state_t;

endpackage

// File: sv/bounded_denominator_fraction_top.sv
// Best rational approximation with bounded denominator, continued-fraction walk.
//
// Input channel (in_valid/in_stall): numerator, denominator and denominator limit.
// in_stall is high whenever an item is in work or its result is waiting.
// Result channel (out_valid/out_stall): reduced numerator and denominator, and
// input_error when the denominator or the limit is zero (inputs passed through).
// Each continued-fraction term costs one restoring division, one bit a cycle,
// then two products on the shared multiplier and the convergent check. When a
// semiconvergent is tested, two more products, a second division and up to two
// more products follow before the result is presented. At most about 46 terms
// fit in 32 bits. An error item skips the divider and goes straight to the result.
// The result waits in its output register while out_stall is high; the next item
// is accepted in the cycle after the result is taken.
// Reset (rst_n low, synchronous) drops any item in work and returns to idle.
`timescale 1ns / 1ps
module bounded_denominator_fraction_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_numerator,
  input  logic [VALUE_WIDTH-1:0] in_denominator,
  input  logic [VALUE_WIDTH-1:0] in_denominator_limit,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_reduced_numerator,
  output logic [VALUE_WIDTH-1:0] out_reduced_denominator,
  output logic                   out_input_error
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

  bdf_pkg::bdf_state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           first_r, first_nxt;
  logic [W-1:0]   pa_r, pa_nxt, pb_r, pb_nxt, qa_r, qa_nxt, qb_r, qb_nxt;
  logic [W-1:0]   pc_r, pc_nxt;
  logic [W-1:0]   bot_r, bot_nxt, lim_r, lim_nxt;
  logic [W-1:0]   quo_r, quo_nxt, rem_r, rem_nxt, dden_r, dden_nxt;
  logic [2*W-1:0] x_r, x_nxt, prod_r, prod_nxt;
  logic [W-1:0]   amin_r, amin_nxt;
  logic [W-1:0]   res_n_r, res_n_nxt, res_d_r, res_d_nxt;
  logic           err_r, err_nxt;

  logic [W-1:0]   mul_a, mul_b;
  logic [W:0]     trial, diff;
  logic           ge;
  logic [W-1:0]   step_rem;
  logic [W-1:0]   step_quo;
  logic [W-1:0]   qc_c;
  logic [W-1:0]   q_half;
  logic           in_acc;

  // shared multiplier, product registered every cycle
  assign prod_nxt = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  // one restoring division step
  assign trial    = {rem_r, quo_r[W-1]};
  assign diff     = trial - {1'b0, dden_r};
  assign ge       = trial >= {1'b0, dden_r};
  assign step_rem = ge ? diff[W-1:0] : trial[W-1:0];
  assign step_quo = {quo_r[W-2:0], ge};

  assign qc_c   = qa_r + prod_r[W-1:0];
  assign q_half = {1'b0, quo_r[W-1:1]};
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    qa_nxt    = qa_r;
    qb_nxt    = qb_r;
    pc_nxt    = pc_r;
    bot_nxt   = bot_r;
    lim_nxt   = lim_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dden_nxt  = dden_r;
    x_nxt     = x_r;
    amin_nxt  = amin_r;
    res_n_nxt = res_n_r;
    res_d_nxt = res_d_r;
    err_nxt   = err_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      bdf_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_denominator == '0 || in_denominator_limit == '0) begin
            res_n_nxt = in_numerator;
            res_d_nxt = in_denominator;
            err_nxt   = 1'b1;
            state_nxt = bdf_pkg::S_OUT;
          end else begin
            pa_nxt    = '0;
            pb_nxt    = W'(1);
            qa_nxt    = W'(1);
            qb_nxt    = '0;
            quo_nxt   = in_numerator;
            rem_nxt   = '0;
            dden_nxt  = in_denominator;
            bot_nxt   = in_denominator;
            lim_nxt   = in_denominator_limit;
            first_nxt = 1'b1;
            err_nxt   = 1'b0;
            cnt_nxt   = '0;
            state_nxt = bdf_pkg::S_DIV;
          end
        end
      end
      bdf_pkg::S_DIV, bdf_pkg::S_ADIV: begin
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == bdf_pkg::S_DIV) ? bdf_pkg::S_MP : bdf_pkg::S_AM1;
        end
      end
      bdf_pkg::S_MP: begin
        mul_a     = pb_r;
        mul_b     = quo_r;
        state_nxt = bdf_pkg::S_MQ;
      end
      bdf_pkg::S_MQ: begin
        pc_nxt    = pa_r + prod_r[W-1:0];
        mul_a     = qb_r;
        mul_b     = quo_r;
        state_nxt = bdf_pkg::S_CHK;
      end
      bdf_pkg::S_CHK: begin
        if (rem_r == '0 || (!first_r && qc_c >= lim_r)) begin
          if (qc_c <= lim_r || qb_r == '0) begin
            res_n_nxt = pc_r;
            res_d_nxt = qc_c;
            err_nxt   = 1'b0;
            state_nxt = bdf_pkg::S_OUT;
          end else begin
            state_nxt = bdf_pkg::S_X1;
          end
        end else begin
          first_nxt = 1'b0;
          pa_nxt    = pb_r;
          pb_nxt    = pc_r;
          qa_nxt    = qb_r;
          qb_nxt    = qc_c;
          quo_nxt   = bot_r;
          rem_nxt   = '0;
          dden_nxt  = rem_r;
          bot_nxt   = rem_r;
          cnt_nxt   = '0;
          state_nxt = bdf_pkg::S_DIV;
        end
      end
      bdf_pkg::S_X1: begin
        // previous remainder equals the current divisor
        mul_a     = qa_r;
        mul_b     = bot_r;
        state_nxt = bdf_pkg::S_X2;
      end
      bdf_pkg::S_X2: begin
        x_nxt     = prod_r;
        mul_a     = rem_r;
        mul_b     = qb_r;
        state_nxt = bdf_pkg::S_X3;
      end
      bdf_pkg::S_X3: begin
        amin_nxt  = (!quo_r[0] && (x_r > prod_r)) ? q_half : q_half + W'(1);
        quo_nxt   = (lim_r >= qa_r) ? lim_r - qa_r : '0;
        rem_nxt   = '0;
        dden_nxt  = qb_r;
        cnt_nxt   = '0;
        state_nxt = bdf_pkg::S_ADIV;
      end
      bdf_pkg::S_AM1: begin
        mul_a = pb_r;
        mul_b = quo_r;
        if (quo_r < amin_r) begin
          res_n_nxt = pb_r;
          res_d_nxt = qb_r;
          err_nxt   = 1'b0;
          state_nxt = bdf_pkg::S_OUT;
        end else begin
          state_nxt = bdf_pkg::S_AM2;
        end
      end
      bdf_pkg::S_AM2: begin
        res_n_nxt = pa_r + prod_r[W-1:0];
        mul_a     = qb_r;
        mul_b     = quo_r;
        state_nxt = bdf_pkg::S_AM3;
      end
      bdf_pkg::S_AM3: begin
        res_d_nxt = qa_r + prod_r[W-1:0];
        err_nxt   = 1'b0;
        state_nxt = bdf_pkg::S_OUT;
      end
      bdf_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = bdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bdf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdf_pkg::S_IDLE;
      cnt_r   <= '0;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    qa_r    <= qa_nxt;
    qb_r    <= qb_nxt;
    pc_r    <= pc_nxt;
    bot_r   <= bot_nxt;
    lim_r   <= lim_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dden_r  <= dden_nxt;
    x_r     <= x_nxt;
    prod_r  <= prod_nxt;
    amin_r  <= amin_nxt;
    res_n_r <= res_n_nxt;
    res_d_r <= res_d_nxt;
    err_r   <= err_nxt;
  end

  assign in_stall                = (state_r != bdf_pkg::S_IDLE);
  assign out_valid               = (state_r == bdf_pkg::S_OUT);
  assign out_reduced_numerator   = res_n_r;
  assign out_reduced_denominator = res_d_r;
  assign out_input_error         = err_r;

  // error items go straight to the output, others enter the divider
  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid == out_input_error))
    else $error("error flag and early result disagree");

  a_den_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_input_error) |->
      (out_reduced_denominator <= lim_r && out_reduced_denominator != '0))
    else $error("result denominator outside limit");

  a_ax_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdf_pkg::S_ADIV) |-> (dden_r != '0))
    else $error("semiconvergent division by zero");

  a_cf_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdf_pkg::S_DIV) |-> (dden_r == bot_r && dden_r != '0))
    else $error("convergent divisor mismatch");

endmodule

// File: dv/tb.sv
// Self-checking testbench for bounded_denominator_fraction_top: predicted best fractions vs DUT.
`timescale 1ns / 1ps
module tb;

  localparam int HALF_PERIOD  = 4;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] numerator;
    logic [31:0] denominator;
    logic [31:0] denominator_limit;
  } frac_item_t;

  typedef struct packed {
    logic [31:0] reduced_numerator;
    logic [31:0] reduced_denominator;
    logic        input_error;
  } fraction_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
  typedef enum {
    SHAPE_WIDE, SHAPE_TINY, SHAPE_FIB, SHAPE_NEAR_ONE, SHAPE_SCALED, SHAPE_ZERO_NUM,
    SHAPE_BAD_INPUT
  } item_shape_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_numerator = '0;
  logic [31:0] in_denominator = '0;
  logic [31:0] in_denominator_limit = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_reduced_numerator;
  logic [31:0] out_reduced_denominator;
  logic        out_input_error;

  frac_item_t  pending_items[$];
  fraction_t   expected_fractions[$];
  logic [31:0] fib[0:47];
  logic        in_taken = 1'b0;
  int          fail_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  int          next_hold_at = 25;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic        stall_toggle = 1'b0;

  bounded_denominator_fraction_top u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_numerator           (in_numerator),
    .in_denominator         (in_denominator),
    .in_denominator_limit   (in_denominator_limit),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_reduced_numerator  (out_reduced_numerator),
    .out_reduced_denominator(out_reduced_denominator),
    .out_input_error        (out_input_error)
  );

  always #HALF_PERIOD clk = ~clk;

  // Continued-fraction walk with the semiconvergent admissibility test, 64-bit exact.
  function automatic fraction_t best_fraction(input frac_item_t item);
    logic [63:0] lim, pa, pb, pc, qa, qb, qc, top, bot, quo, rem, rprev, ax, amin;
    logic        first_term, done;
    fraction_t   res;
    res.input_error = 1'b0;
    if (item.denominator == 0 || item.denominator_limit == 0) begin
      res.reduced_numerator = item.numerator;
      res.reduced_denominator = item.denominator;
      res.input_error = 1'b1;
      return res;
    end
    lim = 64'(item.denominator_limit);
    pa = 64'd0; pb = 64'd1; qa = 64'd1; qb = 64'd0;
    top = 64'(item.numerator); bot = 64'(item.denominator);
    rprev = 64'd0; first_term = 1'b1; done = 1'b0;
    quo = 64'd0; rem = 64'd0; pc = 64'd0; qc = 64'd0;
    while (!done) begin
      quo = top / bot;
      rem = top % bot;
      pc = pa + pb * quo;
      qc = qa + qb * quo;
      if (rem == 0 || (!first_term && qc >= lim)) begin
        done = 1'b1;
      end else begin
        first_term = 1'b0;
        pa = pb; pb = pc;
        qa = qb; qb = qc;
        top = bot;
        bot = rem;
        rprev = rem;
      end
    end
    if (qc <= lim || qb == 0) begin
      res.reduced_numerator = pc[31:0];
      res.reduced_denominator = qc[31:0];
    end else begin
      ax = (lim >= qa) ? (lim - qa) / qb : 64'd0;
      if (quo[0] == 1'b0 && qa * rprev > rem * qb) amin = quo / 2;
      else amin = quo / 2 + 1;
      if (ax < amin) begin
        res.reduced_numerator = pb[31:0];
        res.reduced_denominator = qb[31:0];
      end else begin
        pc = pa + pb * ax;
        qc = qa + qb * ax;
        res.reduced_numerator = pc[31:0];
        res.reduced_denominator = qc[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 16);
      1: return $urandom_range(1, 1000);
      2: return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic frac_item_t random_fraction();
    frac_item_t  item;
    item_shape_t shape;
    int          k;
    logic [31:0] g;
    shape = item_shape_t'($urandom_range(0, 6));
    if ($urandom_range(0, 9) < 4) shape = SHAPE_WIDE;
    item.denominator_limit = pick_limit();
    case (shape)
      SHAPE_TINY: begin
        item.numerator = $urandom_range(1, 1000);
        item.denominator = $urandom_range(1, 1000);
        item.denominator_limit = $urandom_range(1, 50);
      end
      SHAPE_FIB: begin
        k = $urandom_range(20, 47);
        item.numerator = fib[k];
        item.denominator = fib[k-1];
        if ($urandom_range(0, 1) == 1) begin
          item.numerator = fib[k-1];
          item.denominator = fib[k];
        end
      end
      SHAPE_NEAR_ONE: begin
        item.denominator = $urandom | 32'h1;
        item.numerator = item.denominator + $urandom_range(1, 1000);
      end
      SHAPE_SCALED: begin
        g = $urandom_range(1, 4000);
        item.numerator = g * $urandom_range(1, 1_000_000);
        item.denominator = g * $urandom_range(1, 1_000_000);
        item.denominator_limit = $urandom_range(1_000_000, 32'hffff_ffff);
      end
      SHAPE_ZERO_NUM: begin
        item.numerator = '0;
        item.denominator = $urandom | 32'h1;
      end
      SHAPE_BAD_INPUT: begin
        item.numerator = $urandom;
        item.denominator = $urandom;
        case ($urandom_range(0, 2))
          0: item.denominator = '0;
          1: item.denominator_limit = '0;
          default: begin
            item.denominator = '0;
            item.denominator_limit = '0;
          end
        endcase
      end
      default: begin
        item.numerator = $urandom;
        item.denominator = $urandom | ($urandom_range(0, 1) << $urandom_range(0, 31));
        if (item.denominator == 0) item.denominator = 32'h1;
      end
    endcase
    return item;
  endfunction

  task automatic queue_item(input logic [31:0] n, input logic [31:0] d, input logic [31:0] l);
    frac_item_t item;
    item.numerator = n;
    item.denominator = d;
    item.denominator_limit = l;
    pending_items.push_back(item);
  endtask

  initial begin : stimulus
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i <= 47; i++) fib[i] = fib[i-1] + fib[i-2];

    queue_item(32'd0, 32'd5, 32'd10);
    queue_item(32'd6, 32'd4, 32'd100);
    queue_item(32'd123, 32'd0, 32'd7);
    queue_item(32'hffff_ffff, 32'h1234_5678, 32'd0);
    queue_item(32'hffff_ffff, 32'd0, 32'd0);
    queue_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(32'hffff_ffff, 32'd1, 32'd1);
    queue_item(32'd1, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(32'd1, 32'hffff_ffff, 32'd1);
    queue_item(32'd3141592653, 32'd1000000000, 32'd10);
    queue_item(32'd3141592653, 32'd1000000000, 32'd57);
    queue_item(32'd3141592653, 32'd1000000000, 32'd113);
    queue_item(32'd3141592653, 32'd1000000000, 32'd1000);
    queue_item(fib[47], fib[46], 32'hffff_ffff);
    queue_item(fib[46], fib[47], 32'd1000);
    queue_item(32'd864192, 32'd1358016, 32'd11);
    queue_item(32'd864192, 32'd1358016, 32'd1358016);
    queue_item(32'd1414213562, 32'd1000000000, 32'd5);
    queue_item(32'd2718281828, 32'd1000000000, 32'd2);
    queue_item(32'd7, 32'd3, 32'd1);
    queue_item(32'hffff_fffe, 32'hffff_ffff, 32'd2);
    queue_item(32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_items.push_back(random_fraction());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_fractions.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin : input_accept
    frac_item_t item;
    item.numerator = in_numerator;
    item.denominator = in_denominator;
    item.denominator_limit = in_denominator_limit;
    if (rst_n && in_valid && !in_stall) begin
      expected_fractions.push_back(best_fraction(item));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin : item_driver
    frac_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled, hold payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      item = pending_items.pop_front();
      in_numerator <= item.numerator;
      in_denominator <= item.denominator;
      in_denominator_limit <= item.denominator_limit;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
          0: gap_left = 0;
          1: gap_left = $urandom_range(1, 4);
          2: gap_left = $urandom_range(5, 60);
          default: gap_left = $urandom_range(60, 400);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : result_backpressure
    logic stall_next;
    stall_next = 1'b0;
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 600);
    end else begin
      mode_left--;
    end
    stall_toggle = ~stall_toggle;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (results_seen >= next_hold_at) begin
      // long hold-off: DUT fills and holds in_stall while items keep coming
      hold_left = HOLD_CYCLES;
      next_hold_at = (next_hold_at < 100) ? 200 : 32'h7fff_ffff;
      stall_next = 1'b1;
    end else begin
      case (stall_mode)
        STALL_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
        STALL_TOGGLE: stall_next = stall_toggle;
        default:      stall_next = 1'b0;
      endcase
    end
    out_stall <= rst_n ? stall_next : 1'b0;
  end

  always @(posedge clk) begin : result_check
    fraction_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_fractions.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result %h/%h err=%b", $time, out_reduced_numerator,
                 out_reduced_denominator, out_input_error);
      end else begin
        want = expected_fractions.pop_front();
        if (out_reduced_numerator !== want.reduced_numerator) begin
          fail_count++;
          $display("%0t: reduced_numerator expected %h actual %h", $time,
                   want.reduced_numerator, out_reduced_numerator);
        end
        if (out_reduced_denominator !== want.reduced_denominator) begin
          fail_count++;
          $display("%0t: reduced_denominator expected %h actual %h", $time,
                   want.reduced_denominator, out_reduced_denominator);
        end
        if (out_input_error !== want.input_error) begin
          fail_count++;
          $display("%0t: input_error expected %b actual %b", $time,
                   want.input_error, out_input_error);
        end
      end
    end
  end

endmodule

// File: filelist.f
sv/bdf_pkg.sv
sv/bounded_denominator_fraction_top.sv
dv/tb.sv
